// ===== design/mpf_pkg.sv =====
// Shared types and constants for the publish packet framer.
// Used by every module of the block; depends on nothing.
`default_nettype none
package mpf_pkg;

    localparam int C_QUEUE_DEPTH = 4;
    localparam int C_MAX_BYTES   = 6;

    localparam logic [1:0] ST_BYTE    = 2'd0;
    localparam logic [1:0] ST_TOO_BIG = 2'd1;
    localparam logic [1:0] ST_STRAY   = 2'd2;

    localparam logic [7:0] C_PUBLISH_HDR = 8'h30;
    localparam logic [0:0] MODE_START    = 1'b0;

    typedef struct packed {
        logic        mode;
        logic [15:0] topic_length;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
        logic       packet_end;
    } t_out_word;

    // One classified item: the bytes it expands into and how to mark them.
    typedef struct packed {
        logic [2:0]                    count;
        logic [C_MAX_BYTES-1:0][7:0]   bytes;
        logic [1:0]                    status;
        logic                          pend;
    } t_cmd;

endpackage
`default_nettype wire

// ===== design/mqtt_publish_framer.sv =====
// A result word reaches the output through the command queue and the output register after its input word is accepted.
// Throughput: one body word per cycle while results are popped; a start word
// yields 4 to 6 header words, one per cycle, into the single output register.
// A rejected or stray word yields one error word.
// Reset is synchronous and active low: queues empty, no packet open, limit 65535.
// Top level of the publish framer; instantiates mpf_front, mpf_cmdq and mpf_back.
`default_nettype none
module mqtt_publish_framer import mpf_pkg::*; #(
    parameter int QUEUE_DEPTH = C_QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire t_in_word    i_in,
    output logic             empty,
    input  wire logic        pop,
    output t_out_word        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata
);

    logic accept;
    t_cmd front_cmd;
    t_cmd head_cmd;
    logic q_empty;
    logic q_pop;

    assign accept = push && !full;

    mpf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_in        (i_in),
        .o_cmd       (front_cmd)
    );

    mpf_cmdq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (head_cmd),
        .o_empty (q_empty)
    );

    mpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .o_out       (o_out),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule
`default_nettype wire

// ===== design/mpf_front.sv =====
// Front end of the framer: holds the size limit and packet state, classifies
// each accepted word and builds the command for the back end. Uses mpf_pkg.
`default_nettype none
module mpf_front import mpf_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_accept,
    input  wire t_in_word    i_in,
    output t_cmd             o_cmd
);

    logic [15:0] r_limit;
    logic [16:0] r_left, n_left;
    logic        r_open, n_open;

    logic [16:0] body;
    logic [17:0] remaining;
    logic [1:0]  nv;
    logic [7:0]  vb0, vb1, vb2;
    logic [18:0] total;
    logic        too_big;
    logic        empty_body;
    logic        stray;

    always_comb begin
        body       = {1'b0, i_in.topic_length} + {1'b0, i_in.payload_length};
        remaining  = 18'd2 + {1'b0, body};
        empty_body = (body == 17'd0);
        vb0 = {(remaining[17:7] != 11'd0), remaining[6:0]};
        vb1 = {(remaining[17:14] != 4'd0), remaining[13:7]};
        vb2 = {4'd0, remaining[17:14]};
        if (remaining[17:14] != 4'd0) begin
            nv = 2'd3;
        end else if (remaining[17:7] != 11'd0) begin
            nv = 2'd2;
        end else begin
            nv = 2'd1;
        end
        total   = 19'd1 + {17'd0, nv} + {1'b0, remaining};
        too_big = total > {3'd0, r_limit};
        stray   = !r_open || (r_left == 17'd0);
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.count  = 3'd1;
        o_cmd.status = ST_BYTE;
        n_left       = r_left;
        n_open       = r_open;
        if (i_in.mode == MODE_START) begin
            n_left = 17'd0;
            n_open = 1'b0;
            if (too_big) begin
                o_cmd.status = ST_TOO_BIG;
            end else begin
                o_cmd.bytes[0] = C_PUBLISH_HDR;
                o_cmd.bytes[1] = vb0;
                o_cmd.pend     = empty_body;
                unique case (nv)
                    2'd2: begin
                        o_cmd.bytes[2] = vb1;
                        o_cmd.bytes[3] = i_in.topic_length[15:8];
                        o_cmd.bytes[4] = i_in.topic_length[7:0];
                        o_cmd.count    = 3'd5;
                    end
                    2'd3: begin
                        o_cmd.bytes[2] = vb1;
                        o_cmd.bytes[3] = vb2;
                        o_cmd.bytes[4] = i_in.topic_length[15:8];
                        o_cmd.bytes[5] = i_in.topic_length[7:0];
                        o_cmd.count    = 3'd6;
                    end
                    default: begin
                        o_cmd.bytes[2] = i_in.topic_length[15:8];
                        o_cmd.bytes[3] = i_in.topic_length[7:0];
                        o_cmd.count    = 3'd4;
                    end
                endcase
                if (!empty_body) begin
                    n_left = body;
                    n_open = 1'b1;
                end
            end
        end else if (stray) begin
            o_cmd.status = ST_STRAY;
        end else begin
            o_cmd.bytes[0] = i_in.data_byte;
            n_left         = r_left - 17'd1;
            if (r_left == 17'd1) begin
                n_open     = 1'b0;
                o_cmd.pend = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 16'hFFFF;
            r_left  <= 17'd0;
            r_open  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_left <= n_left;
                r_open <= n_open;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/mpf_cmdq.sv =====
// Short command queue between the front and back ends, head shown directly.
// Uses mpf_pkg for the command type.
`default_nettype none
module mpf_cmdq import mpf_pkg::*; #(
    parameter int DEPTH = C_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_data,
    output logic      o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/mpf_back.sv =====
// Back end of the framer: steps through the bytes of the queue head and
// loads them into the output register, one per cycle while it is free. Uses mpf_pkg.
`default_nettype none
module mpf_back import mpf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire logic i_cmd_empty,
    output logic      o_cmd_pop,
    output t_out_word o_out,
    output logic      o_empty,
    input  wire logic i_pop
);

    logic [2:0] r_idx;
    logic       r_ovalid;
    t_out_word  r_out;
    logic       emit;
    logic       final_byte;

    assign emit       = !i_cmd_empty && (!r_ovalid || i_pop);
    assign final_byte = (r_idx == i_cmd.count - 3'd1);
    assign o_cmd_pop  = emit && final_byte;
    assign o_out      = r_out;
    assign o_empty    = !r_ovalid;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.out_byte   <= i_cmd.bytes[r_idx];
            r_out.status     <= i_cmd.status;
            r_out.last       <= final_byte;
            r_out.packet_end <= final_byte && i_cmd.pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= 3'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (emit) begin
                r_idx    <= final_byte ? 3'd0 : r_idx + 3'd1;
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd_empty |-> (r_idx < i_cmd.count))
        else $error("byte index beyond command length");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_empty |-> (r_idx == 3'd0))
        else $error("byte index moved without a command");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.status != ST_BYTE) |-> (r_out.last && !r_out.packet_end))
        else $error("error result not a single closing word");

    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_pop) |=> (r_ovalid && $stable(r_out)))
        else $error("waiting result changed before it was taken");

endmodule
`default_nettype wire

// ===== design/mpf_top.sv =====
`default_nettype none
`default_nettype wire

// ===== verif/mpf_checker.sv =====
// Checker for the publish packet framer: watches the input, result and limit channels,
// predicts every result word and compares it field by field with what the block pops.
// Depends on mpf_pkg for the word types and status codes.
module mpf_checker import mpf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  t_in_word    i_in,
    input  logic        i_empty,
    input  logic        i_pop,
    input  t_out_word   i_out,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    t_out_word   framed_q[$];
    logic [15:0] size_limit  = 16'hFFFF;
    logic [16:0] body_left   = '0;
    logic        packet_open = 1'b0;
    int          fail_count  = 0;
    int          checked     = 0;

    function automatic t_out_word make_word(input logic [7:0] b, input logic [1:0] st,
                                            input logic lst, input logic pe);
        t_out_word w;
        w.out_byte   = b;
        w.status     = st;
        w.last       = lst;
        w.packet_end = pe;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        fail_count++;
        $display("Mismatch on result word %0d: %s got %h expected %h at %0t",
                 checked, what, got, want, $realtime);
    endtask

    task automatic frame_word(input t_in_word w);
        int unsigned body;
        int unsigned remaining;
        int unsigned v;
        int unsigned total;
        int unsigned nv;
        int unsigned i;
        logic [7:0]  groups [3];
        if (w.mode == MODE_START) begin
            body      = w.topic_length + w.payload_length;
            remaining = body + 2;
            v         = remaining;
            nv        = 0;
            do begin
                groups[nv] = {1'b0, v[6:0]};
                v = v >> 7;
                if (v != 0) begin
                    groups[nv][7] = 1'b1;
                end
                nv++;
            end while (v != 0 && nv < 3);
            total       = 1 + nv + remaining;
            packet_open = 1'b0;
            body_left   = '0;
            if (total > size_limit) begin
                framed_q.push_back(make_word(8'h00, ST_TOO_BIG, 1'b1, 1'b0));
            end else begin
                framed_q.push_back(make_word(C_PUBLISH_HDR, ST_BYTE, 1'b0, 1'b0));
                for (i = 0; i < nv; i++) begin
                    framed_q.push_back(make_word(groups[i], ST_BYTE, 1'b0, 1'b0));
                end
                framed_q.push_back(make_word(w.topic_length[15:8], ST_BYTE, 1'b0, 1'b0));
                framed_q.push_back(make_word(w.topic_length[7:0], ST_BYTE, 1'b1, body == 0));
                if (body != 0) begin
                    body_left   = body[16:0];
                    packet_open = 1'b1;
                end
            end
        end else if (!packet_open || body_left == 0) begin
            framed_q.push_back(make_word(8'h00, ST_STRAY, 1'b1, 1'b0));
        end else begin
            body_left = body_left - 17'd1;
            if (body_left == 0) begin
                packet_open = 1'b0;
                framed_q.push_back(make_word(w.data_byte, ST_BYTE, 1'b1, 1'b1));
            end else begin
                framed_q.push_back(make_word(w.data_byte, ST_BYTE, 1'b1, 1'b0));
            end
        end
    endtask

    task automatic check_word(input t_out_word got);
        t_out_word want;
        checked++;
        if (framed_q.size() == 0) begin
            report_mismatch("word with none expected, out_byte", got.out_byte, 8'h00);
        end else begin
            want = framed_q.pop_front();
            if (got.out_byte !== want.out_byte) begin
                report_mismatch("out_byte", got.out_byte, want.out_byte);
            end
            if (got.status !== want.status) begin
                report_mismatch("status", 8'(got.status), 8'(want.status));
            end
            if (got.last !== want.last) begin
                report_mismatch("last", 8'(got.last), 8'(want.last));
            end
            if (got.packet_end !== want.packet_end) begin
                report_mismatch("packet_end", 8'(got.packet_end), 8'(want.packet_end));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            framed_q.delete();
            size_limit  = 16'hFFFF;
            body_left   = '0;
            packet_open = 1'b0;
        end else begin
            if (i_cfg_we) begin
                size_limit = i_cfg_wdata;
            end
            if (i_pop && !i_empty) begin
                check_word(i_out);
            end
            if (i_push && !i_full) begin
                frame_word(i_in);
            end
        end
        o_pending    <= framed_q.size();
        o_fail_count <= fail_count;
        o_checked    <= checked;
    end

endmodule

// ===== verif/tb_top.sv =====
// Top of the publish packet framer testbench: clock, reset, bursty word stimulus,
// a stalling result receiver, limit writes and the final verdict.
// Depends on mpf_pkg, mqtt_publish_framer and mpf_checker.
module tb_top;
    import mpf_pkg::*;

    localparam logic [0:0] MODE_BODY     = 1'b1;
    localparam int         C_CYCLE_LIMIT = 400000;
    localparam int         C_HOLD_CYCLES = 80;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    t_in_word    i_in        = '0;
    logic        pop         = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        full;
    logic        empty;
    t_out_word   o_out;

    int          fail_count;
    int          pending;
    int          checked;
    int          cycle_count    = 0;
    int          words_sent     = 0;
    int          settings_used  = 1;
    int          burst_left     = 0;
    bit          steady         = 1'b0;
    bit          hold_request   = 1'b0;
    int          hold_left      = 0;
    logic [15:0] stall_pattern  = 16'hFFFF;
    logic [3:0]  pat_idx        = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    mqtt_publish_framer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    mpf_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_in         (i_in),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out        (o_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // The receiver follows a rotating stall pattern, and on request holds off entirely
    // for a long stretch so that the block backs up into its input.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = C_HOLD_CYCLES;
            pop <= 1'b0;
        end else begin
            pop <= stall_pattern[pat_idx];
            pat_idx = pat_idx + 4'd1;
            if (pat_idx == 0) begin
                stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                            : (16'($urandom) | 16'h0001);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == C_CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_word(input t_in_word w);
        int gap;
        if (burst_left == 0) begin
            gap = steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        push <= 1'b1;
        i_in <= w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_start(input int tl, input int pl);
        t_in_word w;
        w.mode           = MODE_START;
        w.topic_length   = tl[15:0];
        w.payload_length = pl[15:0];
        w.data_byte      = 8'($urandom);
        send_word(w);
    endtask

    task automatic send_body(input logic [7:0] b);
        t_in_word w;
        w.mode           = MODE_BODY;
        w.topic_length   = 16'($urandom);
        w.payload_length = 16'($urandom);
        w.data_byte      = b;
        send_word(w);
    endtask

    task automatic send_packet(input int tl, input int pl, input int n_body);
        send_start(tl, pl);
        repeat (n_body) send_body(8'($urandom));
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [15:0] v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly complete packets with random content; the rest are truncated packets,
    // random full-range lengths and stray body words.
    task automatic random_phase(input int n_words);
        int stop_at;
        int tl;
        int pl;
        int n;
        int kind;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            steady = ($urandom_range(0, 4) == 0);
            kind   = $urandom_range(0, 99);
            if (kind < 70) begin
                tl = $urandom_range(0, 5);
                pl = $urandom_range(0, 8);
                n  = tl + pl;
                if ($urandom_range(0, 9) == 0) begin
                    n = $urandom_range(0, n);
                end
                send_packet(tl, pl, n);
            end else if (kind < 80) begin
                send_start($urandom, $urandom);
                repeat ($urandom_range(0, 3)) send_body(8'($urandom));
            end else begin
                send_body(8'($urandom));
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_body(8'hFF);
        send_start(0, 0);
        send_body(8'h00);
        send_start(3, 2);
        send_body(8'h00);
        send_body(8'hFF);
        send_body(8'hA5);
        send_body(8'h5A);
        send_body(8'h01);
        send_start(65535, 65535);
        send_start(1, 0);
        send_start(2, 1);
        send_body(8'h80);
        send_body(8'h7F);
        send_body(8'hC3);
        send_start(126, 0);
        send_body(8'h80);
        send_start(16382, 0);
        send_body(8'h7F);
        send_start(65529, 0);
        send_start(65530, 0);

        set_limit(16'd0);
        send_packet(0, 0, 0);
        send_start(65535, 65535);
        send_body(8'($urandom));
        random_phase(8);

        set_limit(16'd10);
        send_packet(3, 3, 6);
        send_start(4, 3);
        random_phase(8);

        set_limit(16'hFFFF);
        steady       = 1'b1;
        hold_request = 1'b1;
        send_packet(10, 20, 30);
        steady = 1'b0;
        random_phase(8);

        set_limit(16'($urandom_range(4, 40)));
        random_phase(8);

        set_limit(16'($urandom));
        random_phase(8);

        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d input words under %0d limit settings; %0d result words compared.",
                 words_sent, settings_used, checked);
        $display("Covered empty, oversized, stray and abandoned packets, 1 to 3 byte lengths, "
                 , "and a full input queue under a long receiver hold.");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
